>>> rtl/slt_pkg.sv
// shared types and codes for the sorted list table
package slt_pkg;

  // operation codes carried by an input item
  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DUMP   = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_PUT,
    S_REM,
    S_DUMP,
    S_FIN
  } state_e;

  // kind of single result pending at the end of an operation
  typedef enum logic [2:0] {
    FIN_INS,
    FIN_CLR,
    FIN_REM,
    FIN_EMPTY,
    FIN_FULL
  } fin_e;

  // walk index update
  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_TOP,
    IDX_ZERO,
    IDX_DEC,
    IDX_INC
  } idx_op_e;

  // memory write selection
  typedef enum logic [2:0] {
    WR_NONE,
    WR_SHIFT,
    WR_ABOVE,
    WR_BOTTOM,
    WR_KEEP
  } wr_op_e;

  // entry count update
  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_ZERO,
    CNT_KEPT
  } cnt_op_e;

  // result register load
  typedef enum logic [2:0] {
    RES_NONE,
    RES_OK,
    RES_EMPTY,
    RES_FULL,
    RES_REMOVE,
    RES_DUMP
  } res_e;

  typedef struct packed {
    logic    load_in;
    idx_op_e idx_op;
    logic    rd_en;
    wr_op_e  wr_op;
    logic    kept_clr;
    logic    kept_inc;
    cnt_op_e cnt_op;
    res_e    res;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic count_full;
    logic idx_zero;
    logic idx_last;
    logic ge;
    logic eq;
    logic out_free;
  } sts_t;

endpackage

>>> rtl/slt_ram.sv
// generic single write port ram with registered read
module slt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/slt_ctrl.sv
// operation sequencer for the sorted list table
module slt_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    mode_i,
  input  slt_pkg::sts_t sts_i,
  output slt_pkg::cmd_t cmd_o
);
  import slt_pkg::*;

  state_e state_q, state_d;
  fin_e   fin_q, fin_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fin_q   <= FIN_EMPTY;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    fin_d   = fin_q;
    cmd_o   = '{load_in: 1'b0, idx_op: IDX_HOLD, rd_en: 1'b0, wr_op: WR_NONE,
                kept_clr: 1'b0, kept_inc: 1'b0, cnt_op: CNT_HOLD, res: RES_NONE};
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          case (mode_e'(mode_i))
            MODE_INSERT: begin
              if (sts_i.count_full) begin
                fin_d   = FIN_FULL;
                state_d = S_FIN;
              end else if (sts_i.count_zero) begin
                state_d = S_INS_PUT;
              end else begin
                cmd_o.idx_op = IDX_TOP;
                cmd_o.rd_en  = 1'b1;
                state_d      = S_INS;
              end
            end
            MODE_DUMP: begin
              if (sts_i.count_zero) begin
                fin_d   = FIN_EMPTY;
                state_d = S_FIN;
              end else begin
                cmd_o.idx_op = IDX_ZERO;
                cmd_o.rd_en  = 1'b1;
                state_d      = S_DUMP;
              end
            end
            MODE_REMOVE: begin
              if (sts_i.count_zero) begin
                fin_d   = FIN_EMPTY;
                state_d = S_FIN;
              end else begin
                cmd_o.idx_op   = IDX_ZERO;
                cmd_o.rd_en    = 1'b1;
                cmd_o.kept_clr = 1'b1;
                state_d        = S_REM;
              end
            end
            MODE_CLEAR: begin
              fin_d   = sts_i.count_zero ? FIN_EMPTY : FIN_CLR;
              state_d = S_FIN;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      // walk down from the top, moving larger or equal entries up one place
      S_INS: begin
        if (sts_i.ge) begin
          cmd_o.wr_op = WR_SHIFT;
          if (sts_i.idx_zero) begin
            state_d = S_INS_PUT;
          end else begin
            cmd_o.idx_op = IDX_DEC;
            cmd_o.rd_en  = 1'b1;
          end
        end else begin
          cmd_o.wr_op = WR_ABOVE;
          fin_d       = FIN_INS;
          state_d     = S_FIN;
        end
      end
      S_INS_PUT: begin
        cmd_o.wr_op = WR_BOTTOM;
        fin_d       = FIN_INS;
        state_d     = S_FIN;
      end
      // compact the table, dropping matching entries
      S_REM: begin
        if (!sts_i.eq) begin
          cmd_o.wr_op    = WR_KEEP;
          cmd_o.kept_inc = 1'b1;
        end
        if (sts_i.idx_last) begin
          fin_d   = FIN_REM;
          state_d = S_FIN;
        end else begin
          cmd_o.idx_op = IDX_INC;
          cmd_o.rd_en  = 1'b1;
        end
      end
      // one result per entry, next read only once the slot is taken
      S_DUMP: begin
        if (sts_i.out_free) begin
          cmd_o.res = RES_DUMP;
          if (sts_i.idx_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.idx_op = IDX_INC;
            cmd_o.rd_en  = 1'b1;
          end
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
          case (fin_q)
            FIN_INS: begin
              cmd_o.res    = RES_OK;
              cmd_o.cnt_op = CNT_INC;
            end
            FIN_CLR: begin
              cmd_o.res    = RES_OK;
              cmd_o.cnt_op = CNT_ZERO;
            end
            FIN_REM: begin
              cmd_o.res    = RES_REMOVE;
              cmd_o.cnt_op = CNT_KEPT;
            end
            FIN_FULL: begin
              cmd_o.res = RES_FULL;
            end
            default: begin
              cmd_o.res = RES_EMPTY;
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/slt_dpath.sv
// storage, walk index and result register of the sorted list table
module slt_dpath #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic signed [31:0] value_i,
  input  slt_pkg::cmd_t      cmd_i,
  output slt_pkg::sts_t      sts_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] item_value_o,
  output logic [4:0]         removed_count_o,
  output logic               last_o
);
  import slt_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic signed [VALUE_WIDTH-1:0] value_q;
  logic [IW-1:0]                 idx_q, idx_d;
  logic [CW-1:0]                 count_q, kept_q;
  logic [VALUE_WIDTH-1:0]        rdata;
  logic                          we;
  logic [IW-1:0]                 waddr;
  logic [VALUE_WIDTH-1:0]        wdata;
  logic                          out_valid_q;
  status_e                       status_q;
  logic signed [31:0]            item_q;
  logic [4:0]                    rcount_q;
  logic                          last_q;
  logic                          none_removed;

  // operand latch, wrapped to the stored width
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      value_q <= VALUE_WIDTH'(value_i);
    end
  end

  // next walk index, also the read address of the RAM
  always_comb begin
    case (cmd_i.idx_op)
      IDX_TOP:  idx_d = IW'(count_q - CW'(1));
      IDX_ZERO: idx_d = '0;
      IDX_DEC:  idx_d = idx_q - IW'(1);
      IDX_INC:  idx_d = idx_q + IW'(1);
      default:  idx_d = idx_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  // write port selection
  always_comb begin
    we    = 1'b1;
    waddr = idx_q + IW'(1);
    wdata = rdata;
    case (cmd_i.wr_op)
      WR_SHIFT: begin
        waddr = idx_q + IW'(1);
        wdata = rdata;
      end
      WR_ABOVE: begin
        waddr = idx_q + IW'(1);
        wdata = value_q;
      end
      WR_BOTTOM: begin
        waddr = '0;
        wdata = value_q;
      end
      WR_KEEP: begin
        waddr = IW'(kept_q);
        wdata = rdata;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  slt_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(idx_d),
    .rdata_o(rdata)
  );

  // entry count and kept count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      kept_q  <= '0;
    end else begin
      if (cmd_i.kept_clr) begin
        kept_q <= '0;
      end else if (cmd_i.kept_inc) begin
        kept_q <= kept_q + CW'(1);
      end
      case (cmd_i.cnt_op)
        CNT_INC:  count_q <= count_q + CW'(1);
        CNT_ZERO: count_q <= '0;
        CNT_KEPT: count_q <= kept_q;
        default:  count_q <= count_q;
      endcase
    end
  end

  // status toward the controller
  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.count_full = (count_q == CW'(DEPTH));
  assign sts_o.idx_zero   = (idx_q == '0);
  assign sts_o.idx_last   = ((CW'(idx_q) + CW'(1)) == count_q);
  assign sts_o.ge         = ($signed(rdata) >= value_q);
  assign sts_o.eq         = (rdata == value_q);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign none_removed = (kept_q == count_q);

  // output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res != RES_NONE) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.res != RES_NONE) begin
      item_q   <= '0;
      rcount_q <= '0;
      last_q   <= 1'b1;
      case (cmd_i.res)
        RES_EMPTY: status_q <= ST_EMPTY;
        RES_FULL:  status_q <= ST_FULL;
        RES_REMOVE: begin
          status_q <= none_removed ? ST_NOT_FOUND : ST_OK;
          rcount_q <= none_removed ? 5'd0 : 5'(count_q - kept_q);
        end
        RES_DUMP: begin
          status_q <= ST_OK;
          item_q   <= 32'($signed(rdata));
          last_q   <= sts_o.idx_last;
        end
        default:   status_q <= ST_OK;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign item_value_o    = item_q;
  assign removed_count_o = rcount_q;
  assign last_o          = last_q;

endmodule

>>> rtl/sorted_list_table.sv
// top level of the sorted list table
// Keeps up to DEPTH signed values in ascending order in a RAM with one
// write port and one registered read port. Each input transfer on
// in_valid_i/in_ready_o carries mode_i and value_i: insert (ahead of equal
// entries), dump, remove all matches, or clear. Results leave on
// out_valid_o/out_ready_i; last_o marks the final result of an operation.
// A dump gives one result per entry (one on an empty table); every other operation gives one.
// An insert on a full table is refused; an insert walks down from the top
// entry, a remove walks the whole table and a dump reads every entry, each
// at one entry per cycle through the one read and one write port of the
// RAM; a dump walk waits while a result is not taken by the receiver.
// A new item is taken as soon as the sequencer is back to idle, while the
// last result may still sit in the output register; a stalled receiver
// holds the walk of a dump and the final result of the next operation.
// Reset empties the table by clearing the entry count; RAM contents are
// not cleared and locations at or above the count are never read.
module sorted_list_table #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] item_value_o,
  output logic [4:0]         removed_count_o,
  output logic               last_o
);
  import slt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  slt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .mode_i    (mode_i),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  slt_dpath #(
    .DEPTH      (DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .value_i        (value_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .item_value_o   (item_value_o),
    .removed_count_o(removed_count_o),
    .last_o         (last_o)
  );

  // any non-ok result closes its operation
  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> last_o)
    else $error("error status without last");

  // a remove count only comes with an ok, final, valueless result
  a_remove_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (removed_count_o != 5'd0) |->
      (status_o == ST_OK) && last_o && (item_value_o == 32'sd0))
    else $error("malformed remove result");

  // the table is never written while the sequencer is idle
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (cmd.wr_op == WR_NONE) && (cmd.cnt_op == CNT_HOLD))
    else $error("table update while idle");

  // a finished result is taken into the output register only when it is free
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.res != RES_NONE) |-> !out_valid_o || out_ready_i)
    else $error("result overwritten before transfer");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for the sorted list table against a shadow table
module testbench;
  import slt_pkg::*;

  localparam int DEPTH       = 16;
  localparam int NUM_ITEMS   = 330;
  localparam int IDLE_LIMIT  = 2000;
  localparam int TAIL_CYCLES = 40;
  localparam int LONG_HOLD   = 300;
  localparam int MAX_REPORTS = 40;

  typedef struct {
    mode_e              mode;
    logic signed [31:0] value;
    bit                 wait_empty;
  } op_t;

  typedef struct {
    status_e            status;
    logic signed [31:0] item_value;
    logic [4:0]         removed_count;
    logic               last;
  } result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  mode_e              in_mode = MODE_INSERT;
  logic signed [31:0] in_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_status;
  logic signed [31:0] out_item_value;
  logic [4:0]         out_removed_count;
  logic               out_last;

  // stimulus, shadow table and expected results
  op_t                pending_ops[$];
  result_t            expected_results[$];
  logic signed [31:0] shadow_entries[DEPTH];
  int                 shadow_count = 0;

  int errors       = 0;
  int idle_cycles  = 0;
  int ops_accepted = 0;

  // sender pacing
  int burst_left = 0;
  int gap_left   = 0;

  // receiver pacing
  int         hold_left  = 0;
  int         holds_done = 0;
  int         style_left = 0;
  int         rx_style   = 0;
  logic [7:0] rx_pattern = 8'hff;

  sorted_list_table dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .mode_i          (in_mode),
    .value_i         (in_value),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .status_o        (out_status),
    .item_value_o    (out_item_value),
    .removed_count_o (out_removed_count),
    .last_o          (out_last)
  );

  always #5 clk_i = ~clk_i;

  function automatic void add_op(mode_e mode, logic signed [31:0] value);
    op_t op;
    op.mode = mode;
    op.value = value;
    op.wait_empty = 1'b0;
    pending_ops.push_back(op);
  endfunction

  // values biased toward duplicates and the signed extremes
  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 6) - 3;
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      2: return $urandom_range(0, 200) - 100;
      default: return $urandom();
    endcase
  endfunction

  function automatic void push_result(status_e status, logic signed [31:0] item,
                                      logic [4:0] removed, logic last);
    result_t r;
    r.status = status;
    r.item_value = item;
    r.removed_count = removed;
    r.last = last;
    expected_results.push_back(r);
  endfunction

  // apply one operation to the shadow table and queue the results it gives
  function automatic void predict_operation(mode_e mode, logic signed [31:0] value);
    int pos;
    int kept;
    if (mode == MODE_INSERT) begin
      if (shadow_count >= DEPTH) begin
        push_result(ST_FULL, '0, '0, 1'b1);
      end else begin
        // new value goes ahead of any equal entries
        pos = 0;
        while (pos < shadow_count && value > shadow_entries[pos]) pos++;
        for (int j = shadow_count; j > pos; j--) shadow_entries[j] = shadow_entries[j-1];
        shadow_entries[pos] = value;
        shadow_count++;
        push_result(ST_OK, '0, '0, 1'b1);
      end
    end else if (shadow_count == 0) begin
      push_result(ST_EMPTY, '0, '0, 1'b1);
    end else if (mode == MODE_DUMP) begin
      for (int j = 0; j < shadow_count; j++)
        push_result(ST_OK, shadow_entries[j], '0, j == shadow_count - 1);
    end else if (mode == MODE_REMOVE) begin
      kept = 0;
      for (int j = 0; j < shadow_count; j++) begin
        if (shadow_entries[j] != value) begin
          shadow_entries[kept] = shadow_entries[j];
          kept++;
        end
      end
      if (kept == shadow_count) begin
        push_result(ST_NOT_FOUND, '0, '0, 1'b1);
      end else begin
        push_result(ST_OK, '0, 5'(shadow_count - kept), 1'b1);
      end
      shadow_count = kept;
    end else begin
      shadow_count = 0;
      push_result(ST_OK, '0, '0, 1'b1);
    end
  endfunction

  // four-state compare so that unknown outputs show up as mismatches
  function automatic void check_field(string name, logic signed [63:0] want,
                                      logic signed [63:0] got);
    if (want !== got) begin
      if (errors < MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // sender: bursts of transfers separated by random gaps
  always @(posedge clk_i) begin : driver
    op_t op;
    bit  offer;
    if (rst_ni) begin
      offer = in_valid && !in_ready;
      if (in_valid && in_ready) begin
        predict_operation(in_mode, in_value);
        ops_accepted++;
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_ops.size() != 0 &&
                     !(pending_ops[0].wait_empty && expected_results.size() != 0)) begin
          op = pending_ops.pop_front();
          in_mode <= op.mode;
          in_value <= op.value;
          offer = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end
        end
        in_valid <= offer;
      end
    end
  end

  // receiver: changing stall styles plus two long hold-offs
  always @(posedge clk_i) begin : receiver
    bit rdy;
    if (rst_ni) begin
      rdy = 1'b1;
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if ((holds_done == 0 && ops_accepted >= 120) ||
                   (holds_done == 1 && ops_accepted >= 260)) begin
        holds_done++;
        hold_left = LONG_HOLD;
        rdy = 1'b0;
      end else begin
        if (style_left == 0) begin
          rx_style = $urandom_range(0, 3);
          style_left = $urandom_range(20, 80);
          rx_pattern = 8'($urandom());
        end else begin
          style_left--;
        end
        case (rx_style)
          0: rdy = 1'b1;
          1: rdy = 1'($urandom_range(0, 1));
          2: rdy = ($urandom_range(0, 3) == 0);
          default: begin
            rdy = rx_pattern[0];
            rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
          end
        endcase
      end
      out_ready <= rdy;
    end
  end

  // result checker and idle watchdog count
  always @(posedge clk_i) begin : monitor
    result_t want;
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          if (errors < MAX_REPORTS)
            $display({"%0t: unexpected result, expected none, ",
                      "actual status %0d item %0d removed %0d last %0b"},
                     $time, out_status, out_item_value, out_removed_count, out_last);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, out_status);
          check_field("item_value", want.item_value, out_item_value);
          check_field("removed_count", want.removed_count, out_removed_count);
          check_field("last", want.last, out_last);
        end
      end
    end
  end

  initial begin : stimulus
    int                 kind;
    int                 start;
    bit                 wait_flag;
    logic signed [31:0] v;
    logic signed [31:0] seq_vals[$];

    // directed: empty cases, extremes, duplicates, remove hit and miss, full table
    add_op(MODE_DUMP, 32'sd9);
    add_op(MODE_REMOVE, 32'sd9);
    add_op(MODE_CLEAR, 32'sd0);
    add_op(MODE_INSERT, 32'sh7fffffff);
    add_op(MODE_INSERT, 32'sh80000000);
    add_op(MODE_INSERT, 32'sd0);
    add_op(MODE_INSERT, -32'sd1);
    add_op(MODE_INSERT, 32'sd5);
    add_op(MODE_INSERT, 32'sd5);
    add_op(MODE_DUMP, 32'sd0);
    add_op(MODE_REMOVE, 32'sd5);
    add_op(MODE_REMOVE, 32'sd12345);
    repeat (12) add_op(MODE_INSERT, 32'sd3);
    add_op(MODE_INSERT, 32'sd3);
    add_op(MODE_DUMP, 32'sd0);
    add_op(MODE_CLEAR, 32'sd0);

    // random: well-formed sequences with some noise
    wait_flag = 1'b1;
    while (pending_ops.size() < NUM_ITEMS) begin
      kind = $urandom_range(0, 9);
      start = pending_ops.size();
      wait_flag = wait_flag || ($urandom_range(0, 5) == 0);
      if (kind < 6) begin
        seq_vals.delete();
        if ($urandom_range(0, 1)) add_op(MODE_CLEAR, rand_value());
        repeat ($urandom_range(1, 18)) begin
          v = rand_value();
          seq_vals.push_back(v);
          add_op(MODE_INSERT, v);
        end
        add_op(MODE_DUMP, rand_value());
        if ($urandom_range(0, 2) != 0) begin
          v = ($urandom_range(0, 2) != 0) ? seq_vals[$urandom_range(0, seq_vals.size() - 1)]
                                         : rand_value();
          add_op(MODE_REMOVE, v);
          add_op(MODE_DUMP, rand_value());
        end
      end else if (kind < 8) begin
        // fill with one value, then remove it all
        v = rand_value();
        add_op(MODE_CLEAR, rand_value());
        repeat ($urandom_range(14, 17)) add_op(MODE_INSERT, v);
        add_op(MODE_REMOVE, v);
        add_op(MODE_DUMP, rand_value());
      end else begin
        repeat ($urandom_range(1, 6)) add_op(mode_e'($urandom_range(0, 3)), rand_value());
      end
      if (wait_flag) pending_ops[start].wait_empty = 1'b1;
      wait_flag = 1'b0;
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(pending_ops.size() == 0 && !in_valid && expected_results.size() == 0) &&
           idle_cycles < IDLE_LIMIT)
      @(posedge clk_i);
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      errors++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      errors++;
    end

    if (errors == 0) begin
      $display("sorted_list_table test passed");
    end else begin
      $display("sorted_list_table test failed");
    end
    $finish;
  end

endmodule

>>> sorted_list_table.f
rtl/slt_pkg.sv
rtl/slt_ram.sv
rtl/slt_ctrl.sv
rtl/slt_dpath.sv
rtl/sorted_list_table.sv
tb/testbench.sv
